>>> rtl/rdar_pkg.sv
// Shared types and codes for the datagram ack and retransmit engine.
`timescale 1ns / 1ps
`default_nettype none
package rdar_pkg;

  localparam int SEQ_W  = 16;
  localparam int TIME_W = 32;

  // command codes
  localparam logic [1:0] CMD_RECV = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_XMIT  = 2'd2;
  localparam logic [1:0] ACT_RETX  = 2'd3;

  // configuration register indexes
  localparam logic CFG_REDELIVER = 1'b0;
  localparam logic CFG_CONN      = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic              is_ack;
    logic [SEQ_W-1:0]  sequence_req;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SEQ_W-1:0] out_sequence;
    logic             deliver;
    logic             duplicate;
    logic             pending_full;
    logic             timed_out;
    logic             last_result;
  } out_word_t;

  // which result the output register takes
  typedef enum logic [1:0] {
    RES_ITEM,
    RES_NONE,
    RES_RETX_MID,
    RES_RETX_LAST
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEEN_RD,
    ST_SEEN_CMP,
    ST_PEND_RD,
    ST_PEND_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_END,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic      load;
    logic      seen_rd;
    logic      seen_inc;
    logic      seen_rec;
    logic      dup_set;
    logic      pend_rd;
    logic      pend_rd_next;
    logic      pend_inc;
    logic      pend_copy;
    logic      pend_dec;
    logic      pend_push;
    logic      restamp;
    logic      hold_load;
    logic      out_load;
    res_kind_t res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       is_ack;
    logic       seen_end;
    logic       seen_match;
    logic       pend_end;
    logic       pend_match;
    logic       pend_last;
    logic       due;
    logic       hold_valid;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/rdar_ctrl.sv
// Sequencing state machine for the datagram ack and retransmit engine.
`timescale 1ns / 1ps
`default_nettype none
module rdar_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rdar_pkg::dp_stat_t stat,
  output rdar_pkg::ctrl_cmd_t cmd
);
  import rdar_pkg::*;

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.command)
          CMD_RECV: state_next = stat.is_ack ? ST_PEND_RD : ST_SEEN_RD;
          CMD_TICK: state_next = ST_TICK_RD;
          default:  state_next = ST_EMIT;
        endcase
      end
      ST_SEEN_RD: begin
        state_next = stat.seen_end ? ST_EMIT : ST_SEEN_CMP;
      end
      ST_SEEN_CMP: begin
        state_next = stat.seen_match ? ST_EMIT : ST_SEEN_RD;
      end
      ST_PEND_RD: begin
        state_next = stat.pend_end ? ST_EMIT : ST_PEND_CMP;
      end
      ST_PEND_CMP: begin
        state_next = stat.pend_match ? ST_SHIFT_RD : ST_PEND_RD;
      end
      ST_SHIFT_RD: begin
        state_next = stat.pend_last ? ST_EMIT : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        state_next = ST_SHIFT_RD;
      end
      ST_TICK_RD: begin
        state_next = stat.pend_end ? ST_TICK_END : ST_TICK_CMP;
      end
      ST_TICK_CMP: begin
        if (!(stat.due && stat.hold_valid && !stat.out_free)) state_next = ST_TICK_RD;
      end
      ST_TICK_END: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.res  = RES_ITEM;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_DISPATCH: begin
        cmd.pend_push = (stat.command == CMD_SEND) && !stat.is_ack;
      end
      ST_SEEN_RD: begin
        cmd.seen_rd  = !stat.seen_end;
        cmd.seen_rec = stat.seen_end;
      end
      ST_SEEN_CMP: begin
        cmd.dup_set  = stat.seen_match;
        cmd.seen_inc = !stat.seen_match;
      end
      ST_PEND_RD: begin
        cmd.pend_rd = !stat.pend_end;
      end
      ST_PEND_CMP: begin
        cmd.pend_inc = !stat.pend_match;
      end
      ST_SHIFT_RD: begin
        cmd.pend_dec     = stat.pend_last;
        cmd.pend_rd      = !stat.pend_last;
        cmd.pend_rd_next = !stat.pend_last;
      end
      ST_SHIFT_WR: begin
        cmd.pend_copy = 1'b1;
        cmd.pend_inc  = 1'b1;
      end
      ST_TICK_RD: begin
        cmd.pend_rd = !stat.pend_end;
      end
      ST_TICK_CMP: begin
        if (!stat.due) begin
          cmd.pend_inc = 1'b1;
        end else if (!stat.hold_valid || stat.out_free) begin
          cmd.out_load  = stat.hold_valid;
          cmd.res       = RES_RETX_MID;
          cmd.restamp   = 1'b1;
          cmd.hold_load = 1'b1;
          cmd.pend_inc  = 1'b1;
        end
      end
      ST_TICK_END: begin
        cmd.out_load = stat.out_free;
        cmd.res      = stat.hold_valid ? RES_RETX_LAST : RES_NONE;
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rdar_datapath.sv
// Tables, counters, timers and the result register of the ack engine.
`timescale 1ns / 1ps
`default_nettype none
module rdar_datapath #(
  parameter int SEEN_DEPTH    = 1024,
  parameter int PENDING_DEPTH = 32,
  parameter int SEQ_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rdar_pkg::in_word_t  in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  rdar_pkg::ctrl_cmd_t cmd,
  output rdar_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output rdar_pkg::out_word_t out_data
);
  import rdar_pkg::*;

  localparam int SW   = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;
  localparam int SAW  = $clog2(SEEN_DEPTH);
  localparam int SCW  = $clog2(SEEN_DEPTH + 1);
  localparam int PAW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);

  // configuration
  logic [TIME_W-1:0] redeliver_timeout, connection_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      redeliver_timeout  <= TIME_W'(3500);
      connection_timeout <= TIME_W'(15000);
    end else if (cfg_we) begin
      if (cfg_index == CFG_REDELIVER) redeliver_timeout <= cfg_data;
      else                            connection_timeout <= cfg_data;
    end
  end

  // current word and connection timer
  in_word_t          item;
  logic [SW-1:0]     item_seq;
  logic              tmo;
  logic [TIME_W-1:0] last_receive_time;
  logic [TIME_W-1:0] lrt_next;

  assign lrt_next = (in_data.command == CMD_RECV) ? in_data.now_ms : last_receive_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_receive_time <= '0;
    end else if (cmd.load) begin
      last_receive_time <= lrt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item     <= in_data;
      item_seq <= in_data.sequence_req[SW-1:0];
      tmo      <= (in_data.now_ms - lrt_next) > connection_timeout;
    end
  end

  // duplicate window: filled in order, so entries below the fill count are valid
  logic [SW-1:0]  seen_mem [SEEN_DEPTH];
  logic [SW-1:0]  seen_rdata;
  logic [SAW-1:0] optr;
  logic [SCW-1:0] fill;
  logic [SCW-1:0] sidx;
  logic           dup;

  always_ff @(posedge clk) begin
    if (cmd.seen_rec) seen_mem[optr] <= item_seq;
    if (cmd.seen_rd)  seen_rdata <= seen_mem[sidx[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      optr <= '0;
      fill <= '0;
    end else if (cmd.seen_rec) begin
      optr <= (optr == SAW'(SEEN_DEPTH - 1)) ? '0 : optr + 1'b1;
      if (fill != SCW'(SEEN_DEPTH)) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)          sidx <= '0;
    else if (cmd.seen_inc) sidx <= sidx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load)         dup <= 1'b0;
    else if (cmd.dup_set) dup <= 1'b1;
  end

  // pending table, kept compacted in insertion order
  logic [SW-1:0]     pseq_mem   [PENDING_DEPTH];
  logic [TIME_W-1:0] pstamp_mem [PENDING_DEPTH];
  logic [SW-1:0]     prd_seq;
  logic [TIME_W-1:0] prd_stamp;
  logic [PCW-1:0]    pcount;
  logic [PCW-1:0]    pidx;
  logic [PCW-1:0]    pnext;
  logic [PAW-1:0]    prd_addr;
  logic              pfull;
  logic              full_flag;

  assign pnext    = pidx + 1'b1;
  assign prd_addr = cmd.pend_rd_next ? pnext[PAW-1:0] : pidx[PAW-1:0];
  assign pfull    = (pcount == PCW'(PENDING_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.pend_push && !pfull) begin
      pseq_mem[pcount[PAW-1:0]]   <= item_seq;
      pstamp_mem[pcount[PAW-1:0]] <= item.now_ms;
    end else if (cmd.pend_copy) begin
      pseq_mem[pidx[PAW-1:0]]   <= prd_seq;
      pstamp_mem[pidx[PAW-1:0]] <= prd_stamp;
    end else if (cmd.restamp) begin
      pstamp_mem[pidx[PAW-1:0]] <= item.now_ms;
    end
    if (cmd.pend_rd) begin
      prd_seq   <= pseq_mem[prd_addr];
      prd_stamp <= pstamp_mem[prd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
    end else if (cmd.pend_push && !pfull) begin
      pcount <= pcount + 1'b1;
    end else if (cmd.pend_dec) begin
      pcount <= pcount - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)          pidx <= '0;
    else if (cmd.pend_inc) pidx <= pnext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load)           full_flag <= 1'b0;
    else if (cmd.pend_push) full_flag <= pfull;
  end

  // retransmit waiting for its last-result mark
  logic          hold_valid;
  logic [SW-1:0] hold_seq;

  always_ff @(posedge clk) begin
    if (rst || cmd.load)    hold_valid <= 1'b0;
    else if (cmd.hold_load) hold_valid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) hold_seq <= prd_seq;
  end

  // result selection
  out_word_t res;

  always_comb begin
    res           = '0;
    res.timed_out = tmo;
    res.last_result = 1'b1;
    case (cmd.res)
      RES_ITEM: begin
        if (item.command == CMD_RECV && !item.is_ack) begin
          res.action       = ACT_ACK;
          res.out_sequence = SEQ_W'(item_seq);
          res.deliver      = !dup;
          res.duplicate    = dup;
        end else if (item.command == CMD_SEND) begin
          res.action       = item.is_ack ? ACT_ACK : ACT_XMIT;
          res.out_sequence = SEQ_W'(item_seq);
          res.pending_full = full_flag;
        end
      end
      RES_RETX_MID: begin
        res.action       = ACT_RETX;
        res.out_sequence = SEQ_W'(hold_seq);
        res.last_result  = 1'b0;
      end
      RES_RETX_LAST: begin
        res.action       = ACT_RETX;
        res.out_sequence = SEQ_W'(hold_seq);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= res;
  end

  // status back to the controller
  always_comb begin
    stat.command    = item.command;
    stat.is_ack     = item.is_ack;
    stat.seen_end   = (sidx == fill);
    stat.seen_match = (seen_rdata == item_seq);
    stat.pend_end   = (pidx == pcount);
    stat.pend_match = (prd_seq == item_seq);
    stat.pend_last  = (pnext >= pcount);
    stat.due        = (item.now_ms - prd_stamp) > redeliver_timeout;
    stat.hold_valid = hold_valid;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

>>> rtl/reliable_datagram_ack_retransmit_core.sv
// Top level of the datagram ack, retransmit and duplicate-window engine.
//
//  channel   direction  handshake              payload
//  in        into core  in_valid / in_stall    in_data   (in_word_t)
//  out       from core  out_valid / out_stall  out_data  (out_word_t)
//  cfg       into core  cfg_we                 cfg_index, cfg_data
//
// One word at a time. Send: dispatched and emitted. Received packet: each
// window entry is read and then compared. Received ack: each pending entry
// is read and compared, then each later entry is moved up. Tick: each pending
// entry is read and checked; one result per due entry, else a no-action one.
// Reset clears the window by its fill count, so there is no clearing pass.
// A stalled output holds the engine only where a new result must be written.
`timescale 1ns / 1ps
`default_nettype none
module reliable_datagram_ack_retransmit_core #(
  parameter int SEEN_DEPTH    = 1024,
  parameter int PENDING_DEPTH = 32,
  parameter int SEQ_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdar_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rdar_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import rdar_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rdar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdar_datapath #(
    .SEEN_DEPTH    (SEEN_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH),
    .SEQ_BITS      (SEQ_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/rdar_checker.sv
// Port-level checks for the ack engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rdar_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rdar_pkg::out_word_t out_data
);
  import rdar_pkg::*;

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one word at a time: an accepted word stalls the input
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // nothing to transmit carries no sequence
  a_none_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == ACT_NONE) |-> (out_data.out_sequence == '0))
    else $error("idle result with a sequence");

  // retransmits carry no receive or send flags
  a_retx_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == ACT_RETX)
      |-> (!out_data.deliver && !out_data.duplicate && !out_data.pending_full))
    else $error("retransmit with flags");

endmodule

bind reliable_datagram_ack_retransmit_core rdar_checker u_rdar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
